// ===== rtl/core/interval_set_table_top_assert.svh =====
// assertion macros for the interval set table
`ifndef INTERVAL_SET_TABLE_TOP_ASSERT_SVH
`define INTERVAL_SET_TABLE_TOP_ASSERT_SVH

// checked only outside reset
`define IST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define IST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ist_pkg.sv =====
`default_nettype none
package ist_pkg;

  localparam int MAX_INTERVALS_DEF = 16;
  localparam int FRAME_BITS_DEF    = 32;
  localparam int PORT_FRAME_W      = 32;

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_POINT   = 2'd2;
  localparam logic [1:0] REQ_OVERLAP = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] lo_frame;
    logic [31:0] hi_frame;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] hit_start;
    logic [31:0] hit_end;
    logic [31:0] last_end;
    logic [4:0]  interval_count;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_REMOVE, OP_POINT, OP_OVERLAP, OP_EMPTY
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] lo;
    logic [31:0] hi;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EX, S_EX2, S_TAIL, S_DONE
  } bst_t;

endpackage
`default_nettype wire

// ===== rtl/core/ist_ram.sv =====
`default_nettype none
module ist_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ist_front.sv =====
`default_nettype none
module ist_front #(
  parameter int FRAME_BITS = ist_pkg::FRAME_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ist_pkg::req_t in_data,
  output logic               q_valid,
  output ist_pkg::item_t     q_item,
  input  wire logic          q_pop
);
  import ist_pkg::*;

  localparam int FW = (FRAME_BITS < PORT_FRAME_W) ? FRAME_BITS : PORT_FRAME_W;

  item_t       cls;
  logic [31:0] lo_m, hi_m;
  item_t       slot_r [2];
  logic        rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;

  function automatic logic [FW-1:0] lo_m_src(input logic [31:0] v);
    return v[FW-1:0];
  endfunction

  // mask to the frame width, then classify
  always_comb begin
    lo_m   = 32'(lo_m_src(in_data.lo_frame));
    hi_m   = 32'(lo_m_src(in_data.hi_frame));
    cls.lo = lo_m;
    cls.hi = hi_m;
    unique case (in_data.req_type)
      REQ_ADD:     cls.op = OP_ADD;
      REQ_REMOVE:  cls.op = OP_REMOVE;
      REQ_POINT:   cls.op = OP_POINT;
      default:     cls.op = OP_OVERLAP;
    endcase
    if (in_data.req_type != REQ_POINT && hi_m <= lo_m) begin
      cls.op = OP_EMPTY;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ist_back.sv =====
`default_nettype none
module ist_back #(
  parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEF,
  parameter int FRAME_BITS    = ist_pkg::FRAME_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire ist_pkg::item_t q_item,
  output logic                q_pop,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output ist_pkg::rsp_t       rsp
);
  import ist_pkg::*;

  localparam int FW = (FRAME_BITS < PORT_FRAME_W) ? FRAME_BITS : PORT_FRAME_W;
  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int NW = $clog2(MAX_INTERVALS + 3);

  bst_t          state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [FW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt, count_r, count_nxt;
  logic [NW-1:0] n_r, n_nxt, n_fin;
  logic          placed_r, placed_nxt, found_r, found_nxt, bank_r, bank_nxt;
  logic [FW-1:0] hs_r, hs_nxt, he_r, he_nxt;
  logic [FW-1:0] ps_r, ps_nxt, pe_r, pe_nxt;
  logic [FW-1:0] last_r, last_nxt, lpe_r, lpe_nxt;
  logic [1:0]    status_r, status_nxt;

  logic          push_v, push_we;
  logic [FW-1:0] push_s, push_e, s, e;
  logic [2*FW-1:0] rd0, rd1, rdw;
  logic [AW-1:0] raddr;

  ist_ram #(.WIDTH(2*FW), .DEPTH(MAX_INTERVALS)) u_bank0 (
    .clk(clk), .we(push_we && bank_r), .waddr(n_r[AW-1:0]),
    .wdata({push_s, push_e}), .raddr(raddr), .rdata(rd0)
  );
  ist_ram #(.WIDTH(2*FW), .DEPTH(MAX_INTERVALS)) u_bank1 (
    .clk(clk), .we(push_we && !bank_r), .waddr(n_r[AW-1:0]),
    .wdata({push_s, push_e}), .raddr(raddr), .rdata(rd1)
  );

  assign raddr   = i_r[AW-1:0];
  assign rdw     = bank_r ? rd1 : rd0;
  assign s       = rdw[2*FW-1:FW];
  assign e       = rdw[FW-1:0];
  assign push_we = push_v && (n_r < NW'(MAX_INTERVALS));

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    placed_nxt = placed_r;
    found_nxt  = found_r;
    hs_nxt     = hs_r;
    he_nxt     = he_r;
    ps_nxt     = ps_r;
    pe_nxt     = pe_r;
    bank_nxt   = bank_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    lpe_nxt    = lpe_r;
    status_nxt = status_r;
    push_v     = 1'b0;
    push_s     = s;
    push_e     = e;
    n_fin      = n_r;
    q_pop      = 1'b0;
    rsp_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          op_nxt     = q_item.op;
          lo_nxt     = q_item.lo[FW-1:0];
          hi_nxt     = q_item.hi[FW-1:0];
          i_nxt      = '0;
          n_nxt      = '0;
          placed_nxt = 1'b0;
          found_nxt  = 1'b0;
          hs_nxt     = '0;
          he_nxt     = '0;
          status_nxt = (q_item.op == OP_EMPTY) ? ST_EMPTY : ST_DONE;
          state_nxt  = (q_item.op == OP_EMPTY) ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        state_nxt = (i_r < count_r) ? S_EX : S_TAIL;
      end
      S_EX: begin
        i_nxt     = i_r + CW'(1);
        state_nxt = S_RD;
        unique case (op_r)
          OP_ADD: begin
            if (e < lo_r) begin
              push_v = 1'b1;
            end else if (s > hi_r) begin
              push_v = 1'b1;
              if (!placed_r) begin
                push_s     = lo_r;
                push_e     = hi_r;
                placed_nxt = 1'b1;
                ps_nxt     = s;
                pe_nxt     = e;
                state_nxt  = S_EX2;
              end
            end else begin
              if (s < lo_r) lo_nxt = s;
              if (e > hi_r) hi_nxt = e;
            end
          end
          OP_REMOVE: begin
            if (e <= lo_r || s >= hi_r) begin
              push_v = 1'b1;
            end else if (s < lo_r) begin
              push_v = 1'b1;
              push_e = lo_r;
              if (e > hi_r) begin
                ps_nxt    = hi_r;
                pe_nxt    = e;
                state_nxt = S_EX2;
              end
            end else if (e > hi_r) begin
              push_v = 1'b1;
              push_s = hi_r;
            end
          end
          OP_POINT: begin
            if (!found_r && lo_r >= s && lo_r < e) begin
              found_nxt = 1'b1;
              hs_nxt    = s;
              he_nxt    = e;
            end
          end
          OP_OVERLAP: begin
            if (s < hi_r && e > lo_r) found_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      S_EX2: begin
        push_v    = 1'b1;
        push_s    = ps_r;
        push_e    = pe_r;
        state_nxt = S_RD;
      end
      S_TAIL: begin
        // add not yet placed lands at the end
        if (op_r == OP_ADD && !placed_r) begin
          push_v = 1'b1;
          push_s = lo_r;
          push_e = hi_r;
        end
        n_fin = n_r + NW'(push_v);
        if (op_r == OP_ADD || op_r == OP_REMOVE) begin
          if (n_fin > NW'(MAX_INTERVALS)) begin
            status_nxt = ST_FULL;
          end else begin
            bank_nxt  = !bank_r;
            count_nxt = CW'(n_fin);
            if (n_fin == '0) last_nxt = '0;
            else last_nxt = push_v ? push_e : lpe_r;
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (push_v && state_r != S_TAIL) begin
      n_nxt   = n_r + NW'(1);
      lpe_nxt = push_e;
    end
  end

  always_comb begin
    rsp.found          = found_r;
    rsp.hit_start      = 32'(hs_r);
    rsp.hit_end        = 32'(he_r);
    rsp.last_end       = 32'(last_r);
    rsp.interval_count = 5'(count_r);
    rsp.status         = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bank_r   <= 1'b0;
      count_r  <= '0;
      last_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      bank_r   <= bank_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    i_r      <= i_nxt;
    n_r      <= n_nxt;
    placed_r <= placed_nxt;
    found_r  <= found_nxt;
    hs_r     <= hs_nxt;
    he_r     <= he_nxt;
    ps_r     <= ps_nxt;
    pe_r     <= pe_nxt;
    lpe_r    <= lpe_nxt;
    status_r <= status_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/interval_set_table_top.sv =====
// path to out_valid: the queue holds the request until the back end pops it; an empty
// span goes straight to the result, else the back end checks each stored interval in
// turn, with an extra step when an add lands before one or a remove splits one, then
// writes any tail. throughput: one request at a time, the back end is busy for the whole
// walk and while its result waits on out_stall; a 2-beat queue takes new beats meanwhile
// reset: synchronous active-low rst_n empties the table, clears last_end and the queues
`default_nettype none
module interval_set_table_top #(
  parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEF,
  parameter int FRAME_BITS    = ist_pkg::FRAME_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ist_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ist_pkg::rsp_t      out_data
);
  import ist_pkg::*;

  // queue between front and back
  logic  q_valid, q_pop;
  item_t q_item;

  // result from the back end
  logic  rsp_valid, rsp_ready;
  rsp_t  rsp;

  // output register
  logic  out_valid_r, out_valid_nxt;
  rsp_t  out_data_r;

  // front: mask, classify, queue
  ist_front #(.FRAME_BITS(FRAME_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // back: walks the table, writes the rebuilt table into the other bank
  ist_back #(.MAX_INTERVALS(MAX_INTERVALS), .FRAME_BITS(FRAME_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // register is free when empty or its beat leaves this cycle
  assign rsp_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_ready) out_valid_nxt = rsp_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/ist_checker.sv =====
`default_nettype none
`include "interval_set_table_top_assert.svh"
module ist_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire ist_pkg::rsp_t out_data
);
  import ist_pkg::*;

  `IST_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled beat changed")
  `IST_ASSERT(a_status, out_valid |-> out_data.status != 2'd3, "bad status code")
  `IST_ASSERT(a_miss_zero, out_valid && !out_data.found |-> out_data.hit_start == '0 && out_data.hit_end == '0, "hit fields set without a hit")
  `IST_ASSERT(a_empty, out_valid && out_data.status != ST_DONE |-> !out_data.found, "found on ignored or rejected beat")
  `IST_ASSERT_RST(a_rst, !rst_n |=> !out_valid, "beat out of reset")

endmodule

bind interval_set_table_top ist_checker u_ist_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
`default_nettype wire
